/* rtl/btm_pkg.sv */
// btm_pkg: shared widths, codes and command/status types for the bitmap trie core
// depends on: nothing
package btm_pkg;

    // payload widths
    localparam int LETTER_W  = 8;
    localparam int INDEX_W   = 12;
    localparam int ALPHA_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;

    // bitmap word geometry
    localparam int WORD_BITS = 64;
    localparam int BIT_SEL_W = 6;

    // letter and index constants
    localparam logic [LETTER_W-1:0] LETTER_A     = 8'd97;
    localparam logic [ALPHA_W-1:0]  ALPHA_MAX    = 7'd64;
    localparam logic [INDEX_W-1:0]  POISON_INDEX = 12'hFFF;
    localparam int                  POISON_INT   = 4095;

    // reset value of the alphabet size configuration register
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 7'd4;

    // operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BASED    = 1'd1;

    // controller to datapath commands
    typedef struct packed {
        logic clear;
        logic load_in;
        logic calc;
        logic update;
    } btm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
    } btm_status_t;

endpackage

/* rtl/btm_if.sv */
// btm_if: valid/ready channel interfaces for the input and result words
// depends on: btm_pkg
interface btm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [btm_pkg::LETTER_W-1:0]  letter_byte;
    logic                          first_letter;
    logic                          last_letter;

    modport source (output valid, output func, output letter_byte, output first_letter,
                    output last_letter, input ready);
    modport sink   (input valid, input func, input letter_byte, input first_letter,
                    input last_letter, output ready);
endinterface

interface btm_out_if;
    logic                         valid;
    logic                         ready;
    logic [btm_pkg::INDEX_W-1:0]  node_index;
    logic                         found;
    logic                         out_of_range;
    logic                         word_done;

    modport source (output valid, output node_index, output found, output out_of_range,
                    output word_done, input ready);
    modport sink   (input valid, input node_index, input found, input out_of_range,
                    input word_done, output ready);
endinterface

/* rtl/btm_ctrl.sv */
// btm_ctrl: controller state machine sequencing clear pass, index, read and update
// depends on: btm_pkg
module btm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output btm_pkg::btm_cmd_t    cmd,
    input  btm_pkg::btm_status_t status
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_READ,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // output register can take a word when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    cmd.update     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/btm_dpath.sv */
// btm_dpath: config registers, prefix index arithmetic, bitmap memories and result word
// depends on: btm_pkg
module btm_dpath #(
    parameter int BITMAP_WORDS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [btm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [btm_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  btm_pkg::btm_cmd_t               cmd,
    output btm_pkg::btm_status_t            status,
    input  logic                            in_func,
    input  logic [btm_pkg::LETTER_W-1:0]    in_letter_byte,
    input  logic                            in_first_letter,
    input  logic                            in_last_letter,
    output logic [btm_pkg::INDEX_W-1:0]     out_node_index,
    output logic                            out_found,
    output logic                            out_out_of_range,
    output logic                            out_word_done
);

    localparam int ADDR_W      = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int CAPACITY    = BITMAP_WORDS * btm_pkg::WORD_BITS;
    localparam int INDEX_LIMIT = (CAPACITY < btm_pkg::POISON_INT) ? CAPACITY
                                                                  : btm_pkg::POISON_INT;
    localparam int PROD_W      = btm_pkg::INDEX_W + btm_pkg::ALPHA_W;
    localparam int SUM_W       = PROD_W + 1;

    // configuration registers
    logic [btm_pkg::ALPHA_W-1:0] alpha_size_reg;
    logic                        zero_based_reg;

    // captured input word
    logic                           func_reg;
    logic [btm_pkg::LETTER_W-1:0]   letter_reg;
    logic                           first_reg;
    logic                           last_reg;

    // running word state
    logic [btm_pkg::INDEX_W-1:0] prefix_reg, prefix_next;
    logic                        match_reg, match_next;

    // computed index
    logic [btm_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic                        bad_reg, bad_next;

    // clear pass
    logic [ADDR_W-1:0] clr_addr_reg;

    // bitmap memories and registered read data
    logic [btm_pkg::WORD_BITS-1:0] node_mem [BITMAP_WORDS];
    logic [btm_pkg::WORD_BITS-1:0] end_mem  [BITMAP_WORDS];
    logic [btm_pkg::WORD_BITS-1:0] node_rd_reg;
    logic [btm_pkg::WORD_BITS-1:0] end_rd_reg;

    // index arithmetic
    logic [btm_pkg::ALPHA_W-1:0]  alpha_eff;
    logic [btm_pkg::LETTER_W-1:0] letter_ofs;
    logic                         bad_letter;
    logic [btm_pkg::ALPHA_W-1:0]  letter_val;
    logic [btm_pkg::INDEX_W-1:0]  base;
    logic [PROD_W-1:0]            prod;
    logic [SUM_W-1:0]             sum;

    // update stage
    logic [ADDR_W-1:0]             word_addr;
    logic [btm_pkg::BIT_SEL_W-1:0] bit_sel;
    logic [btm_pkg::WORD_BITS-1:0] bit_mask;
    logic                          match_eff;
    logic                          search_hit;
    logic                          do_write;
    logic                          node_we, end_we;
    logic [ADDR_W-1:0]             wr_addr;
    logic [btm_pkg::WORD_BITS-1:0] node_wdata, end_wdata;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_size_reg <= btm_pkg::ALPHA_RESET;
            zero_based_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                btm_pkg::CFG_ALPHABET_SIZE: alpha_size_reg <= cfg_data;
                btm_pkg::CFG_ZERO_BASED:    zero_based_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg   <= in_func;
            letter_reg <= in_letter_byte;
            first_reg  <= in_first_letter;
            last_reg   <= in_last_letter;
        end
    end

    // prefix index = base * alphabet + letter value, with range checks
    always_comb
    begin
        alpha_eff  = (alpha_size_reg > btm_pkg::ALPHA_MAX) ? btm_pkg::ALPHA_MAX
                                                           : alpha_size_reg;
        letter_ofs = letter_reg - btm_pkg::LETTER_A;
        bad_letter = (letter_reg < btm_pkg::LETTER_A)
                     || (letter_ofs >= {1'b0, alpha_eff});
        letter_val = letter_ofs[btm_pkg::ALPHA_W-1:0]
                     + (zero_based_reg ? 7'd0 : 7'd1);
        base       = first_reg ? '0 : prefix_reg;
        prod       = base * alpha_eff;
        sum        = {1'b0, prod} + SUM_W'(letter_val);
        bad_next   = bad_letter || (sum >= SUM_W'(INDEX_LIMIT));
        idx_next   = bad_next ? btm_pkg::POISON_INDEX : sum[btm_pkg::INDEX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            idx_reg <= idx_next;
            bad_reg <= bad_next;
        end
    end

    // word address and bit position of the current index
    assign word_addr = ADDR_W'(idx_reg >> btm_pkg::BIT_SEL_W);
    assign bit_sel   = idx_reg[btm_pkg::BIT_SEL_W-1:0];
    assign bit_mask  = btm_pkg::WORD_BITS'(1) << bit_sel;

    // match logic and next word state
    always_comb
    begin
        match_eff  = first_reg ? 1'b1 : match_reg;
        search_hit = match_eff && node_rd_reg[bit_sel]
                     && (!last_reg || end_rd_reg[bit_sel]);
        if (bad_reg)
        begin
            match_next = 1'b0;
        end
        else if (func_reg == btm_pkg::FUNC_SEARCH)
        begin
            match_next = search_hit;
        end
        else
        begin
            match_next = match_eff;
        end
        prefix_next = idx_reg;
        if (last_reg)
        begin
            prefix_next = '0;
            match_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            match_reg  <= 1'b1;
        end
        else if (cmd.update)
        begin
            prefix_reg <= prefix_next;
            match_reg  <= match_next;
        end
    end

    // clear pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign status.clear_done = (clr_addr_reg == ADDR_W'(BITMAP_WORDS - 1));

    // memory write port: clear pass or insert read-modify-write
    assign do_write   = cmd.update && !bad_reg && (func_reg == btm_pkg::FUNC_INSERT);
    assign node_we    = cmd.clear || do_write;
    assign end_we     = cmd.clear || (do_write && last_reg);
    assign wr_addr    = cmd.clear ? clr_addr_reg : word_addr;
    assign node_wdata = cmd.clear ? '0 : (node_rd_reg | bit_mask);
    assign end_wdata  = cmd.clear ? '0 : (end_rd_reg | bit_mask);

    // bitmap memories
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[wr_addr] <= node_wdata;
        end
        if (end_we)
        begin
            end_mem[wr_addr] <= end_wdata;
        end
        node_rd_reg <= node_mem[word_addr];
        end_rd_reg  <= end_mem[word_addr];
    end

    // result word register
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_node_index   <= idx_reg;
            out_found        <= !bad_reg && (func_reg == btm_pkg::FUNC_SEARCH) && search_hit;
            out_out_of_range <= bad_reg;
            out_word_done    <= last_reg;
        end
    end

endmodule

/* rtl/bitmap_trie_membership_core.sv */
// bitmap_trie_membership_core: top level of the bitmap trie string set
// depends on: btm_pkg, btm_if, btm_ctrl, btm_dpath
//
// Usage:
// - in_word carries one character per word: func (insert or search), letter_byte,
//   first_letter and last_letter. out_word returns one result word per input word:
//   node_index, found, out_of_range and word_done.
// - cfg_we/cfg_index/cfg_data write alphabet_size (index 0) and zero_based_letters
//   (index 1); write only while the core is idle.
// - Sequencing: one character at a time, through accept, index multiply-add, bitmap
//   read and read-modify-write update; the next character is accepted only after the
//   update step, which waits while the result register is not free.
// - Result: out_word.valid rises when the update step writes the result register.
// - Reset: both bitmaps are cleared by a sweep over all BITMAP_WORDS words, one word per
//   cycle; in_word.ready stays low during the sweep. Prefix index returns to 0, the
//   match flag to 1, alphabet_size to 4 and zero_based_letters to 0.
// - Stall: the result register holds its word while out_word.ready is low; the next
//   character is still accepted and computed, then waits in the update step until
//   the result register is free.
module bitmap_trie_membership_core #(
    parameter int BITMAP_WORDS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [btm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [btm_pkg::CFG_DAT_W-1:0] cfg_data,
    btm_in_if.sink                        in_word,
    btm_out_if.source                     out_word
);

    btm_pkg::btm_cmd_t    cmd;
    btm_pkg::btm_status_t status;

    // sequencing
    btm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_word.valid),
        .in_ready  (in_word.ready),
        .out_valid (out_word.valid),
        .out_ready (out_word.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // arithmetic, bitmaps and result register
    btm_dpath #(
        .BITMAP_WORDS (BITMAP_WORDS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .status           (status),
        .in_func          (in_word.func),
        .in_letter_byte   (in_word.letter_byte),
        .in_first_letter  (in_word.first_letter),
        .in_last_letter   (in_word.last_letter),
        .out_node_index   (out_word.node_index),
        .out_found        (out_word.found),
        .out_out_of_range (out_word.out_of_range),
        .out_word_done    (out_word.word_done)
    );

endmodule

/* rtl/btm_checker.sv */
// btm_checker: port-level assertions for the bitmap trie core, bound to the top level
// depends on: btm_pkg, bitmap_trie_membership_core
module btm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [btm_pkg::INDEX_W-1:0]  node_index,
    input logic                         found,
    input logic                         out_of_range,
    input logic                         word_done
);

    // a stalled result word stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(node_index) && $stable(found)
                                    && $stable(out_of_range) && $stable(word_done))
        else $error("result payload changed while stalled");

    // an error result carries the poison index and no match
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> node_index == btm_pkg::POISON_INDEX && !found)
        else $error("error result without poison index");

    // one character in flight: ready drops after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second word accepted while one is in flight");

    // an accepted word, with no result pending, does not make out_valid rise at once
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

endmodule

bind bitmap_trie_membership_core btm_checker u_btm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_word.valid),
    .in_ready     (in_word.ready),
    .out_valid    (out_word.valid),
    .out_ready    (out_word.ready),
    .node_index   (out_word.node_index),
    .found        (out_word.found),
    .out_of_range (out_word.out_of_range),
    .word_done    (out_word.word_done)
);
